// File: rtl/trd_pkg.sv
package trd_pkg;

  localparam int VALUE_BITS = 31;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DECIDE,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic   done;
    value_t quotient;
    value_t remainder;
  } div_res_t;

endpackage

// File: rtl/trial_division_primality.sv
// Trial-division primality test.
//
// Input channel: candidate with in_valid / in_stall. A word is taken when
// in_valid is high and in_stall is low. in_stall stays high from the cycle
// after a word is taken until its result is loaded into the output register.
// Output channel: is_prime and bad_input with out_valid / out_stall. The
// result sits in an output register until the receiver drops out_stall; the
// next candidate may be taken while it waits there.
// Candidates 0 and 1 go straight to the result without division. Otherwise
// each trial divisor takes one run of the shared bit-serial divider, which
// yields quotient and remainder together, then a step for its done flag and one
// to decide; divisors run from 2 up to about sqrt(candidate).
// A zero candidate raises bad_input with is_prime low.
// Reset (rst, synchronous) returns to idle and drops out_valid; a test in
// progress is abandoned. While the receiver stalls, a finished test waits
// before its result is loaded, and the input stays stalled.
module trial_division_primality (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  trd_pkg::value_t candidate,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            is_prime,
  output logic            bad_input
);
  import trd_pkg::*;

  state_t   state;
  state_t   state_next;
  value_t   n;
  value_t   d;
  logic     prime_r;
  logic     bad_r;
  logic     accept;
  logic     below_two;
  logic     div_start;
  logic     out_load;
  logic     out_free;
  logic     past_bound;
  logic     divides;
  logic     kick;
  logic     start_any;
  div_res_t div_res;

  assign accept     = in_valid & ~in_stall;
  assign below_two  = (candidate < value_t'(2));
  assign out_free   = ~out_valid | ~out_stall;
  assign past_bound = (d > div_res.quotient);
  assign divides    = (div_res.remainder == '0);
  assign start_any  = div_start | kick;

  trd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start_any),
    .dividend (n),
    .divisor  (d),
    .res      (div_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = below_two ? ST_REPORT : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_res.done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = (past_bound || divides) ? ST_REPORT : ST_DIVIDE;
      end
      ST_REPORT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_DIVIDE: div_start = 1'b0;
      ST_DECIDE: div_start = ~(past_bound | divides);
      ST_REPORT: out_load = out_free;
      default:   in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // first division starts in the cycle after the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      kick <= 1'b0;
    end else begin
      kick <= accept & ~below_two;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n       <= candidate;
      d       <= value_t'(2);
      prime_r <= 1'b0;
      bad_r   <= (candidate == '0);
    end else if (state == ST_DECIDE) begin
      if (past_bound) begin
        prime_r <= 1'b1;
      end else if (~divides) begin
        d <= d + value_t'(1);
      end
    end
    if (out_load) begin
      is_prime  <= prime_r;
      bad_input <= bad_r;
    end
  end

endmodule

// File: rtl/trd_div.sv
module trd_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  trd_pkg::value_t dividend,
  input  trd_pkg::value_t divisor,
  output trd_pkg::div_res_t res
);
  import trd_pkg::*;

  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(VALUE_BITS - 1);

  value_t              quo;
  value_t              rem;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic                done;
  logic [VALUE_BITS:0] trial;
  logic [VALUE_BITS:0] diff;
  logic                fits;

  always_comb begin
    trial = {rem, quo[VALUE_BITS-1]};
    diff  = trial - {1'b0, divisor};
    fits  = ~diff[VALUE_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      // shift one dividend bit in, subtract when it fits
      quo <= {quo[VALUE_BITS-2:0], fits};
      rem <= fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

// File: rtl/trd_checker.sv
module trd_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input trd_pkg::value_t candidate,
  input logic            out_valid,
  input logic            out_stall,
  input logic            is_prime,
  input logic            bad_input
);

  a_bad_not_prime: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(bad_input && is_prime))
    else $error("bad_input and is_prime both set");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled while a word is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no word in work");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(is_prime) && $stable(bad_input)))
    else $error("stalled result changed");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> (in_valid && $stable(candidate)))
    else $error("stalled input word changed");

endmodule

bind trial_division_primality trd_checker u_trd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .candidate (candidate),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .is_prime  (is_prime),
  .bad_input (bad_input)
);

// File: tb/sv/primality_checker.sv
module primality_checker
  import trd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  logic   in_stall,
  input  value_t candidate,
  input  logic   out_valid,
  input  logic   out_stall,
  input  logic   is_prime,
  input  logic   bad_input,
  output int     errors,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    value_t cand;
    logic   prime;
    logic   zero;
  } verdict_t;

  verdict_t verdicts_due[$];

  function automatic verdict_t primality_of(value_t n);
    longint unsigned v;
    longint unsigned d;
    verdict_t r;
    v = longint'(n);
    r.cand = n;
    r.zero = (n == '0);
    r.prime = 1'b0;
    if (v >= 2) begin
      r.prime = 1'b1;
      for (d = 2; d <= v / d; d++) begin
        if (v % d == 0) begin
          r.prime = 1'b0;
          break;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst) begin
      verdicts_due.delete();
      errors = 0;
    end else begin
      // check the outgoing word before taking a new candidate
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("result word with no candidate pending (is_prime=%b bad_input=%b)",
                                    is_prime, bad_input));
        end else begin
          want = verdicts_due.pop_front();
          if (is_prime !== want.prime)
            report_mismatch($sformatf("candidate %0d: is_prime %b, want %b",
                                      want.cand, is_prime, want.prime));
          if (bad_input !== want.zero)
            report_mismatch($sformatf("candidate %0d: bad_input %b, want %b",
                                      want.cand, bad_input, want.zero));
        end
      end
      if (in_valid && !in_stall)
        verdicts_due.push_back(primality_of(candidate));
    end
    pending <= verdicts_due.size();
  end

endmodule

// File: tb/sv/trial_division_primality_tb.sv
module trial_division_primality_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import trd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 40_000_000;
  localparam int unsigned SETTLE      = 64;
  localparam int unsigned N_DIRECTED  = 24;

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  value_t candidate = '0;
  logic   out_stall = 1'b0;
  logic   in_stall;
  logic   out_valid;
  logic   is_prime;
  logic   bad_input;

  int          errors;
  int          pending;
  int unsigned send_idle = 17;
  int unsigned recv_idle = 57;
  int unsigned cycles    = 0;

  value_t directed [N_DIRECTED] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 25, 49, 121, 169, 1009, 65536, 65537, 999983,
    1018081, 1022117, 1073741824, 2147483645, 2147483646, 2147483647
  };

  always #6 clk = ~clk;

  trial_division_primality DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .candidate (candidate),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_prime  (is_prime),
    .bad_input (bad_input)
  );

  primality_checker verdict_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .candidate (candidate),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_prime  (is_prime),
    .bad_input (bad_input),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push(value_t v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    candidate <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every verdict has been delivered
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_batch(int unsigned count);
    value_t          v;
    longint unsigned a;
    longint unsigned b;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2, 3: v = value_t'($urandom_range(4095));
        4, 5:       v = value_t'($urandom_range(20'hFFFFF));
        6:          v = value_t'($urandom() & 32'h7FFF_FFFE);
        7:          v = value_t'(3 * $urandom_range(715827882, 1));
        default: begin
          a = $urandom_range(999, 3) | 1;
          b = $urandom_range(999, 3) | 1;
          v = value_t'(a * b);
        end
      endcase
      push(v);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) push(directed[i]);
    random_batch(26);
    drain();
    send_idle = 57;
    recv_idle <= 17;
    random_batch(25);
    drain();
    send_idle = 0;
    recv_idle <= 0;
    random_batch(25);
    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
